FILE: src/dedup_pkg.sv
// Shared constants and types for the deduplicating union table.
`default_nettype none

package dedup_pkg;

	localparam int CAPACITY = 64;
	localparam int VAL_W    = 32;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic kept;
		idx_t position;
		cnt_t count;
		logic full_res;
		logic done_res;
	} out_word_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		val_t wr_data;
		val_t key;
	} store_req_t;

	typedef struct packed {
		logic valid;
		idx_t addr;
		logic hit;
	} store_rsp_t;

endpackage

`default_nettype wire

FILE: src/dedup_ifs.sv
// Valid/ready channel interfaces for input and result words.
`default_nettype none

interface dedup_in_if;
	import dedup_pkg::*;

	logic              valid;
	logic              ready;
	logic signed [VAL_W-1:0] value;
	logic              from_first;
	logic              start_new;
	logic              last_item;

	modport source (output valid, value, from_first, start_new, last_item, input ready);
	modport sink   (input valid, value, from_first, start_new, last_item, output ready);
endinterface

interface dedup_out_if;
	import dedup_pkg::*;

	logic       valid;
	logic       ready;
	logic       kept;
	idx_t       position;
	cnt_t       count;
	logic       full_res;
	logic       done_res;

	modport source (output valid, kept, position, count, full_res, done_res, input ready);
	modport sink   (input valid, kept, position, count, full_res, done_res, output ready);
endinterface

`default_nettype wire

FILE: src/dedup_store.sv
// Value store: synchronous memory with registered read and key compare.
`default_nettype none

module dedup_store (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dedup_pkg::store_req_t req,
	output dedup_pkg::store_rsp_t      rsp
);
	import dedup_pkg::*;

	val_t mem_q [CAPACITY];
	val_t rdata_s1;
	idx_t addr_s1;
	logic valid_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem_q[req.rd_addr];
			addr_s1  <= req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.rd_en;
		end
	end

	assign rsp.valid = valid_s1;
	assign rsp.addr  = addr_s1;
	assign rsp.hit   = valid_s1 && (rdata_s1 == req.key);

endmodule

`default_nettype wire

FILE: src/dedup_union_table.sv
// Union of two value lists without duplicates, linear search over a memory store.
// A first-list item, or any item into an empty store, is appended without a search;
//   a second-list item is first compared against the stored entries in turn until a match.
// Throughput: one word at a time; the search reads one memory entry per cycle.
// Reset clears the entry count and all control; memory contents stay undefined
//   and are never read before written, so there is no clearing pass.
`default_nettype none

module dedup_union_table (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dedup_in_if.sink    in_ch,
	dedup_out_if.source out_ch
);
	import dedup_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_APPEND = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;
	cnt_t       cnt_q;
	cnt_t       issue_q;
	val_t       val_q;
	logic       last_q;
	out_word_t  res_q;
	out_word_t  out_q;
	logic       out_valid_q;

	store_req_t req;
	store_rsp_t rsp;
	logic       accept;
	logic       emit_load;
	logic       has_room;
	cnt_t       eff_cnt;

	dedup_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign emit_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);
	assign has_room    = (cnt_q < CNT_W'(CAPACITY));
	assign eff_cnt     = in_ch.start_new ? '0 : cnt_q;

	// appends land at cnt_q, beyond every entry searched, so no forwarding is needed
	always_comb begin
		req.rd_en   = (state_q == ST_SEARCH) && (issue_q < cnt_q);
		req.rd_addr = issue_q[IDX_W-1:0];
		req.wr_en   = (state_q == ST_APPEND) && has_room;
		req.wr_addr = cnt_q[IDX_W-1:0];
		req.wr_data = val_q;
		req.key     = val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			issue_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= eff_cnt;
						issue_q <= '0;
						if (in_ch.from_first || (eff_cnt == '0)) begin
							state_q <= ST_APPEND;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (req.rd_en) begin
						issue_q <= issue_q + 1'b1;
					end
					if (rsp.hit) begin
						state_q <= ST_EMIT;
					end else if (rsp.valid && ({1'b0, rsp.addr} + 1'b1 == cnt_q)) begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (has_room) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q  <= in_ch.value;
			last_q <= in_ch.last_item;
		end
		if ((state_q == ST_SEARCH) && rsp.hit) begin
			res_q.kept     <= 1'b0;
			res_q.position <= rsp.addr;
			res_q.count    <= cnt_q;
			res_q.full_res <= 1'b0;
			res_q.done_res <= last_q;
		end else if (state_q == ST_APPEND) begin
			res_q.kept     <= has_room;
			res_q.position <= has_room ? cnt_q[IDX_W-1:0] : '0;
			res_q.count    <= has_room ? cnt_q + 1'b1 : cnt_q;
			res_q.full_res <= !has_room;
			res_q.done_res <= last_q;
		end
		if (emit_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.kept     = out_q.kept;
	assign out_ch.position = out_q.position;
	assign out_ch.count    = out_q.count;
	assign out_ch.full_res = out_q.full_res;
	assign out_ch.done_res = out_q.done_res;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en |-> (issue_q < cnt_q) && (state_q == ST_SEARCH))
		else $error("search read beyond stored entries");

	a_kept_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kept) |-> ({1'b0, out_q.position} + 1'b1 == out_q.count))
		else $error("kept word position does not match count");

	a_full_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.full_res) |->
			(!out_q.kept && (out_q.count == CNT_W'(CAPACITY))))
		else $error("full flag without full store");
`endif

endmodule

`default_nettype wire
